### rtl/plvh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plvh_pkg
// Shared types and constants of the price level volume histogram.
// ----------------------------------------------------------------------------
package plvh_pkg;

    // field widths fixed by the item formats
    localparam int SUM_W    = 48;
    localparam int PRICE_W  = 32;
    localparam int AMOUNT_W = 32;
    localparam int SIZE_W   = 16;
    localparam int BASE_W   = 32;
    localparam int RIDX_W   = 10;
    localparam int REP_W    = 16;
    localparam int PIX_W    = 16;
    localparam int PROD_W   = 49;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 296;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // divider: numerator 2*price + size, denominator 2*size
    localparam int DIV_W    = 34;
    localparam int DEN_W    = 17;
    localparam int DCNT_W   = 6;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [REP_W-1:0] REP_MAX = {REP_W{1'b1}};

    // request kinds
    localparam logic CMD_TRADE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // result status codes
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_DROP = 1'b1;

    // register indexes
    localparam logic REG_BIN_SIZE = 1'b0;
    localparam logic REG_BASE_BIN = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RMW,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [SIZE_W-1:0] bin_size;
        logic [BASE_W-1:0] base_bin;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

endpackage

### rtl/plvh_apb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plvh_apb
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module plvh_apb (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [plvh_pkg::APB_AW-1:0] paddr,
    input  logic [plvh_pkg::APB_DW-1:0] pwdata,
    output logic [plvh_pkg::APB_DW-1:0] prdata,
    output plvh_pkg::cfg_t              cfg
);
    import plvh_pkg::*;

    logic [SIZE_W-1:0] bin_size_reg;
    logic [BASE_W-1:0] base_bin_reg;
    logic              reg_sel;
    logic              wr_fire;

    // register select from the word address
    assign reg_sel = paddr[2];
    assign wr_fire = psel & penable & pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_size_reg <= SIZE_W'(1);
            base_bin_reg <= '0;
        end else if (wr_fire) begin
            unique case (reg_sel)
                REG_BIN_SIZE: bin_size_reg <= pwdata[SIZE_W-1:0];
                REG_BASE_BIN: base_bin_reg <= pwdata[BASE_W-1:0];
                default:      ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_sel)
            REG_BIN_SIZE: prdata = APB_DW'(bin_size_reg);
            REG_BASE_BIN: prdata = APB_DW'(base_bin_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.bin_size = bin_size_reg;
    assign cfg.base_bin = base_bin_reg;

endmodule

### rtl/plvh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plvh_div
// Restoring divider, one quotient bit per cycle, for the bin number.
// ----------------------------------------------------------------------------
module plvh_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  plvh_pkg::div_req_t req,
    output plvh_pkg::div_rsp_t rsp
);
    import plvh_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  nq_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W:0]    rem_shift;
    logic              fits;

    // shift in the next numerator bit and try the subtract
    assign rem_shift = {rem_reg, nq_reg[DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // numerator and quotient share one shift register
    always_ff @(posedge aclk) begin
        if (req.start) begin
            nq_reg  <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            nq_reg  <= {nq_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DEN_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = nq_reg;

endmodule

### rtl/plvh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plvh_ram
// Bin store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plvh_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 128,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/price_level_volume_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_volume_histogram
// Volume profile: trades accumulate into price bins, bins are read and cleared.
// ----------------------------------------------------------------------------
// Path: a trade runs through the bit-serial divider (S_DIV), then S_RMW and S_FIN
//   into the output register; a dropped trade skips S_RMW, a bin read skips S_DIV.
// Requests: one at a time; the next is taken once the result is in the output
//   register.
// Reset: after aresetn the store is cleared, one bin per cycle, during which
//   no request is taken; registers return to size 1, base 0.
// ----------------------------------------------------------------------------
module price_level_volume_histogram #(
    parameter int NUM_BINS   = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // trade_price[31:0], trade_amount[63:32], read_index[73:64], zero pad
    input  logic [plvh_pkg::S_DATA_W-1:0] s_tdata,
    // cmd[0], sell_side[1]
    input  logic [1:0]                    s_tuser,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // level_price[47:0], bid_sum[95:48], ask_sum[143:96], bid_trades[159:144],
    // ask_trades[175:160], level_delta[224:176], level_volume[273:225],
    // level_trades[290:274], zero pad
    output logic [plvh_pkg::M_DATA_W-1:0] m_tdata,
    // status[0]
    output logic [0:0]                    m_tuser,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [plvh_pkg::APB_AW-1:0]   paddr,
    input  logic [plvh_pkg::APB_DW-1:0]   pwdata,
    output logic [plvh_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import plvh_pkg::*;

    localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int ENT_W = 2 * SUM_W + 2 * COUNT_BITS;
    localparam int CB    = COUNT_BITS;

    // configuration
    cfg_t              cfg;
    logic [SIZE_W-1:0] size_eff;

    // control
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              s_fire;
    logic              m_fire;
    logic              out_free;

    // request context
    logic              cmd_reg;
    logic              sell_reg;
    logic [AMOUNT_W-1:0] amount_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [PIX_W-1:0]  pidx_reg;
    logic              hit_reg;
    logic              drop_reg;

    // divider
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic [DIV_W-1:0]  bin_diff;
    logic              bin_ok;

    // read request decode
    logic [16:0]       rix_ext;
    logic              rix_ok;

    // memory ports
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [ENT_W-1:0]  ram_wr_data;
    logic              ram_rd_en;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [ENT_W-1:0]  ram_rd_data;

    // read-modify-write
    logic [ENT_W-1:0]  ent_cur;
    logic [SUM_W-1:0]  bid_cur, ask_cur;
    logic [CB-1:0]     bidn_cur, askn_cur;
    logic [SUM_W:0]    sum_add;
    logic [CB:0]       cnt_add;
    logic [SUM_W-1:0]  sum_sat;
    logic [CB-1:0]     cnt_sat;
    logic [ENT_W-1:0]  ent_new;
    logic [ENT_W-1:0]  ent_res_reg;
    logic [BASE_W:0]   base_plus;
    logic [PROD_W-1:0] prod_reg;

    // result formatting
    logic [SUM_W-1:0]  r_bid, r_ask, r_price;
    logic [REP_W-1:0]  r_bidn, r_askn;
    logic [SUM_W:0]    r_delta, r_volume;
    logic [REP_W:0]    r_trades;
    logic [M_DATA_W-1:0] r_data;
    logic              r_status;

    // output register
    logic              out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic              out_status_reg;

    // ------------------------------------------------------------------
    // submodules
    // ------------------------------------------------------------------
    plvh_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    plvh_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    plvh_ram #(
        .DEPTH  (NUM_BINS),
        .WIDTH  (ENT_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign pready = 1'b1;

    // zero bin size acts as one
    assign size_eff = (cfg.bin_size == '0) ? SIZE_W'(1) : cfg.bin_size;

    assign s_fire   = s_tvalid & s_tready;
    assign m_fire   = out_valid_reg & m_tready;
    assign out_free = ~out_valid_reg | m_tready;

    // divider operands: round half up as (2p + s) / (2s)
    assign div_req.start = s_fire & (s_tuser[0] == CMD_TRADE);
    assign div_req.num   = DIV_W'({s_tdata[PRICE_W-1:0], 1'b0}) + DIV_W'(size_eff);
    assign div_req.den   = {size_eff, 1'b0};

    // bin range check on the quotient
    assign bin_diff = div_rsp.quot - DIV_W'(cfg.base_bin);
    assign bin_ok   = (div_rsp.quot >= DIV_W'(cfg.base_bin)) &&
                      (bin_diff < DIV_W'(NUM_BINS));

    // read index range check
    assign rix_ext = 17'(s_tdata[PRICE_W+AMOUNT_W +: RIDX_W]);
    assign rix_ok  = rix_ext < 17'(NUM_BINS);

    // ------------------------------------------------------------------
    // state machine: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(NUM_BINS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    state_next = (s_tuser[0] == CMD_TRADE) ? S_DIV : S_RMW;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = bin_ok ? S_RMW : S_FIN;
                end
            end
            S_RMW: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // state machine: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_tready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = rix_ext[IDX_W-1:0];
        unique case (state_reg)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_cnt_reg;
            end
            S_IDLE: begin
                s_tready  = 1'b1;
                ram_rd_en = s_fire & (s_tuser[0] == CMD_READ) & rix_ok;
            end
            S_DIV: begin
                ram_rd_en   = div_rsp.done & bin_ok;
                ram_rd_addr = bin_diff[IDX_W-1:0];
            end
            S_RMW: begin
                ram_wr_en   = hit_reg;
                ram_wr_data = (cmd_reg == CMD_TRADE) ? ent_new : '0;
            end
            S_FIN: ;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // request context capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg    <= s_tuser[0];
            sell_reg   <= s_tuser[1];
            amount_reg <= s_tdata[PRICE_W +: AMOUNT_W];
            idx_reg    <= rix_ext[IDX_W-1:0];
            pidx_reg   <= PIX_W'(rix_ext);
            hit_reg    <= (s_tuser[0] == CMD_READ) & rix_ok;
            drop_reg   <= 1'b0;
        end else if (state_reg == S_DIV && div_rsp.done) begin
            idx_reg  <= bin_diff[IDX_W-1:0];
            pidx_reg <= PIX_W'(bin_diff[IDX_W-1:0]);
            hit_reg  <= bin_ok;
            drop_reg <= ~bin_ok;
        end
    end

    // ------------------------------------------------------------------
    // modify: saturating add on the selected side
    // ------------------------------------------------------------------
    always_comb begin
        ent_cur  = hit_reg ? ram_rd_data : '0;
        bid_cur  = ent_cur[0 +: SUM_W];
        ask_cur  = ent_cur[SUM_W +: SUM_W];
        bidn_cur = ent_cur[2*SUM_W +: CB];
        askn_cur = ent_cur[2*SUM_W+CB +: CB];

        sum_add = (SUM_W+1)'(sell_reg ? bid_cur : ask_cur) + (SUM_W+1)'(amount_reg);
        cnt_add = (CB+1)'(sell_reg ? bidn_cur : askn_cur) + (CB+1)'(1);
        sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        cnt_sat = cnt_add[CB] ? {CB{1'b1}} : cnt_add[CB-1:0];

        if (sell_reg) begin
            ent_new = {askn_cur, cnt_sat, ask_cur, sum_sat};
        end else begin
            ent_new = {cnt_sat, bidn_cur, sum_sat, bid_cur};
        end
    end

    // bin price product
    assign base_plus = (BASE_W+1)'(cfg.base_bin) + (BASE_W+1)'(pidx_reg);

    // updated or old entry, and the price product
    always_ff @(posedge aclk) begin
        if (state_reg == S_RMW) begin
            ent_res_reg <= (cmd_reg == CMD_TRADE) ? ent_new : ent_cur;
            prod_reg    <= PROD_W'(base_plus) * PROD_W'(size_eff);
        end
    end

    // ------------------------------------------------------------------
    // result formatting
    // ------------------------------------------------------------------
    always_comb begin
        logic [32:0] bn_ext;
        logic [32:0] an_ext;
        bn_ext   = 33'(ent_res_reg[2*SUM_W +: CB]);
        an_ext   = 33'(ent_res_reg[2*SUM_W+CB +: CB]);
        r_bid    = ent_res_reg[0 +: SUM_W];
        r_ask    = ent_res_reg[SUM_W +: SUM_W];
        r_bidn   = (bn_ext > 33'(REP_MAX)) ? REP_MAX : bn_ext[REP_W-1:0];
        r_askn   = (an_ext > 33'(REP_MAX)) ? REP_MAX : an_ext[REP_W-1:0];
        r_price  = prod_reg[PROD_W-1] ? SUM_MAX : prod_reg[SUM_W-1:0];
        r_delta  = (SUM_W+1)'(r_ask) - (SUM_W+1)'(r_bid);
        r_volume = (SUM_W+1)'(r_ask) + (SUM_W+1)'(r_bid);
        r_trades = (REP_W+1)'(r_askn) + (REP_W+1)'(r_bidn);
        if (drop_reg) begin
            r_data   = '0;
            r_status = ST_DROP;
        end else begin
            r_data   = M_DATA_W'({r_trades, r_volume, r_delta, r_askn, r_bidn,
                                  r_ask, r_bid, r_price});
            r_status = ST_DONE;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == S_FIN && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN && out_free) begin
            out_data_reg   <= r_data;
            out_status_reg <= r_status;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_status_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_req_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("request taken during store clear");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("second request taken while one is in flight");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide wait");

    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] == ST_DROP)) |-> (m_tdata == '0))
        else $error("dropped trade result carries data");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> !ram_rd_en)
        else $error("store read and write in the same cycle");

endmodule

### tb/tb_price_level_volume_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_price_level_volume_histogram
// Self-checking bench for the volume profile block: trades and bin reads are
// streamed in, every result is predicted from a local copy of the bin store
// and the two registers, and compared against the block's output in order.
// ----------------------------------------------------------------------------
module tb_price_level_volume_histogram;
    import plvh_pkg::*;

    typedef longint unsigned u64_t;

    localparam int NUM_BINS       = 1024;
    localparam int COUNT_BITS     = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int HOT_BINS       = 16;
    localparam int SETTLE_CYCLES  = 40;
    localparam logic [APB_AW-1:0] ADDR_BIN_SIZE = {REG_BIN_SIZE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_BASE_BIN = {REG_BASE_BIN, 2'b00};
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // one bin report as it leaves the block
    typedef struct packed {
        logic              status;
        logic [SUM_W-1:0]  price;
        logic [SUM_W-1:0]  bid;
        logic [SUM_W-1:0]  ask;
        logic [REP_W-1:0]  bid_n;
        logic [REP_W-1:0]  ask_n;
        logic [48:0]       delta;
        logic [48:0]       volume;
        logic [16:0]       trades;
    } level_report_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [0:0]            m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_AW-1:0]     paddr    = '0;
    logic [APB_DW-1:0]     pwdata   = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // local copy of the bin store and registers
    logic [SUM_W-1:0]      book_bid  [NUM_BINS];
    logic [SUM_W-1:0]      book_ask  [NUM_BINS];
    logic [COUNT_BITS-1:0] book_bidn [NUM_BINS];
    logic [COUNT_BITS-1:0] book_askn [NUM_BINS];
    logic [SIZE_W-1:0]     cfg_bin_size = 16'd1;
    logic [BASE_W-1:0]     cfg_base_bin = 32'd0;

    level_report_t         pending_levels[$];
    int unsigned           mismatch_count = 0;
    int unsigned           idle_cycles    = 0;
    int unsigned           src_idle_pct   = 0;
    int unsigned           snk_stall_pct  = 0;
    int unsigned           holdoff_left   = 0;

    price_level_volume_histogram #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    initial begin
        for (int i = 0; i < NUM_BINS; i++) begin
            book_bid[i]  = '0;
            book_ask[i]  = '0;
            book_bidn[i] = '0;
            book_askn[i] = '0;
        end
    end

    // report of one bin with its derived fields
    function automatic level_report_t describe_bin(u64_t idx, logic [SUM_W-1:0] bid,
                                                   logic [SUM_W-1:0] ask,
                                                   logic [COUNT_BITS-1:0] bidn,
                                                   logic [COUNT_BITS-1:0] askn);
        level_report_t r;
        u64_t size;
        u64_t px;
        r = '0;
        size = (cfg_bin_size == 0) ? 1 : cfg_bin_size;
        px = cfg_base_bin;
        px = (px + idx) * size;
        r.status = ST_DONE;
        r.price  = (px > SUM_MAX) ? SUM_MAX : px[SUM_W-1:0];
        r.bid    = bid;
        r.ask    = ask;
        r.bid_n  = (bidn > REP_MAX) ? REP_MAX : bidn[REP_W-1:0];
        r.ask_n  = (askn > REP_MAX) ? REP_MAX : askn[REP_W-1:0];
        r.delta  = {1'b0, ask} - {1'b0, bid};
        r.volume = {1'b0, ask} + {1'b0, bid};
        r.trades = {1'b0, r.ask_n} + {1'b0, r.bid_n};
        return r;
    endfunction

    // apply one request to the local store and return the expected report
    function automatic level_report_t predict_level(logic cmd, logic [31:0] price,
                                                    logic [31:0] amount, logic sell,
                                                    logic [RIDX_W-1:0] ridx);
        level_report_t r;
        u64_t size;
        u64_t p;
        u64_t bin;
        u64_t idx;
        u64_t sum;
        r = '0;
        size = (cfg_bin_size == 0) ? 1 : cfg_bin_size;
        if (cmd == CMD_TRADE) begin
            p = price;
            bin = (2 * p + size) / (2 * size);
            if (bin < cfg_base_bin || bin - cfg_base_bin >= NUM_BINS) begin
                r.status = ST_DROP;
                return r;
            end
            idx = bin - cfg_base_bin;
            if (sell) begin
                sum = book_bid[idx];
                sum = sum + amount;
                book_bid[idx] = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
                if (book_bidn[idx] != CNT_MAX)
                    book_bidn[idx] = book_bidn[idx] + 1'b1;
            end else begin
                sum = book_ask[idx];
                sum = sum + amount;
                book_ask[idx] = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
                if (book_askn[idx] != CNT_MAX)
                    book_askn[idx] = book_askn[idx] + 1'b1;
            end
            r = describe_bin(idx, book_bid[idx], book_ask[idx], book_bidn[idx],
                             book_askn[idx]);
        end else begin
            idx = ridx;
            if (idx >= NUM_BINS) begin
                r = describe_bin(idx, '0, '0, '0, '0);
            end else begin
                r = describe_bin(idx, book_bid[idx], book_ask[idx], book_bidn[idx],
                                 book_askn[idx]);
                book_bid[idx]  = '0;
                book_ask[idx]  = '0;
                book_bidn[idx] = '0;
                book_askn[idx] = '0;
            end
        end
        return r;
    endfunction

    // result receiver with random stalls and an optional long hold-off
    always @(posedge aclk) begin
        if (holdoff_left != 0) begin
            m_tready <= 1'b0;
            holdoff_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // register tracking, prediction on each request, check of each result
    always @(posedge aclk) begin : scoreboard
        level_report_t got;
        level_report_t want;
        level_report_t exp_level;
        logic s_fire;
        logic m_fire;
        if (aresetn) begin
            s_fire = s_tvalid && s_tready;
            m_fire = m_tvalid && m_tready;
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_BIN_SIZE)
                    cfg_bin_size = pwdata[SIZE_W-1:0];
                else if (paddr == ADDR_BASE_BIN)
                    cfg_base_bin = pwdata[BASE_W-1:0];
            end
            if (m_fire) begin
                got.status = m_tuser[0];
                got.price  = m_tdata[47:0];
                got.bid    = m_tdata[95:48];
                got.ask    = m_tdata[143:96];
                got.bid_n  = m_tdata[159:144];
                got.ask_n  = m_tdata[175:160];
                got.delta  = m_tdata[224:176];
                got.volume = m_tdata[273:225];
                got.trades = m_tdata[290:274];
                if (pending_levels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: st=%0d px=%h", got.status, got.price);
                end else begin
                    want = pending_levels.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display({"mismatch exp: st=%0d px=%h bid=%h ask=%h bn=%h",
                                      " an=%h dl=%h vol=%h tr=%h"},
                                     want.status, want.price, want.bid, want.ask, want.bid_n,
                                     want.ask_n, want.delta, want.volume, want.trades);
                            $display({"         got: st=%0d px=%h bid=%h ask=%h bn=%h",
                                      " an=%h dl=%h vol=%h tr=%h"},
                                     got.status, got.price, got.bid, got.ask, got.bid_n,
                                     got.ask_n, got.delta, got.volume, got.trades);
                        end
                    end
                end
            end
            if (s_fire) begin
                exp_level = predict_level(s_tuser[0], s_tdata[31:0], s_tdata[63:32],
                                          s_tuser[1], s_tdata[73:64]);
                pending_levels = {pending_levels, exp_level};
            end
            // watchdog on cycles with no request and no result moving
            if (s_fire || m_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // offer one request and wait until it is taken
    task automatic send_request(logic cmd, logic [31:0] price, logic [31:0] amount,
                                logic sell, logic [RIDX_W-1:0] ridx);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, ridx, amount, price};
        s_tuser  <= {sell, cmd};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_trade(logic [31:0] price, logic [31:0] amount, logic sell);
        send_request(CMD_TRADE, price, amount, sell, RIDX_W'($urandom_range(1023)));
    endtask

    task automatic send_read(logic [RIDX_W-1:0] ridx);
        send_request(CMD_READ, $urandom, $urandom, 1'($urandom_range(1)), ridx);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_levels.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_bins(logic [SIZE_W-1:0] size, logic [BASE_W-1:0] base);
        drain();
        apb_write(ADDR_BIN_SIZE, {16'd0, size});
        apb_write(ADDR_BASE_BIN, base);
    endtask

    // random base that keeps most bins reachable by a 32 bit price
    function automatic logic [BASE_W-1:0] pick_base(logic [SIZE_W-1:0] size);
        u64_t top;
        top = 64'hFFFF_FFFF / ((size == 0) ? 1 : size);
        top = (top > NUM_BINS) ? top - NUM_BINS : 0;
        return BASE_W'($urandom_range(top[31:0]));
    endfunction

    // mostly trades aimed at live bins, some stray prices, reads mostly of hot bins
    task automatic issue_random_item();
        int unsigned roll;
        int unsigned idx;
        u64_t size;
        u64_t lo;
        u64_t p;
        logic [31:0] amt;
        roll = $urandom_range(99);
        size = (cfg_bin_size == 0) ? 1 : cfg_bin_size;
        case ($urandom_range(9))
            0, 1:    amt = 32'hFFFF_FFFF;
            2:       amt = 32'd0;
            default: amt = $urandom;
        endcase
        idx = ($urandom_range(99) < 70) ? $urandom_range(HOT_BINS - 1)
                                        : $urandom_range(NUM_BINS - 1);
        if (roll < 55) begin
            lo = cfg_base_bin;
            lo = (lo + idx) * size;
            p = lo + $urandom_range(size - 1);
            if (lo >= size / 2)
                p = p - size / 2;
            if (p > 64'hFFFF_FFFF)
                p = $urandom;
            send_trade(p[31:0], amt, 1'($urandom_range(1)));
        end else if (roll < 65) begin
            send_trade($urandom, amt, 1'($urandom_range(1)));
        end else begin
            send_read(RIDX_W'(idx));
        end
    endtask

    // reset values of the registers: size 1, base 0
    task automatic test_default_bins();
        send_trade(32'd0, 32'd0, 1'b0);
        send_trade(32'd0, 32'hFFFF_FFFF, 1'b1);
        send_trade(32'd1023, 32'd5, 1'b0);
        send_trade(32'd1024, 32'd9, 1'b1);          // just above the top bin
        send_trade(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_read(10'd0);
        send_read(10'd0);                           // bin cleared by the read before
        send_read(10'd1023);
        send_trade(32'd7, 32'd100, 1'b1);
        send_trade(32'd7, 32'd40, 1'b0);            // negative delta
        send_read(10'd7);
        drain();
    endtask

    // register extremes, zero bin size, half-tick rounding, both drop sides
    task automatic test_register_extremes();
        set_bins(16'd0, 32'd0);
        send_trade(32'd5, 32'd11, 1'b0);
        send_read(10'd5);
        set_bins(16'hFFFF, 32'hFFFF_FFFF);
        send_trade(32'd0, 32'd3, 1'b0);             // below the first bin
        send_trade(32'hFFFF_FFFF, 32'd3, 1'b1);
        send_read(10'd1023);
        send_read(10'd0);
        set_bins(16'd2, 32'd3);
        send_trade(32'd5, 32'd1, 1'b0);             // exact half rounds up
        send_trade(32'd4, 32'd1, 1'b1);
        send_trade(32'd2052, 32'd2, 1'b1);
        send_trade(32'd2054, 32'd2, 1'b0);          // one past the top bin
        send_read(10'd0);
        send_read(10'd1023);
        set_bins(16'd1, 32'hFFFF_FFFF);
        send_trade(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_read(10'd0);
        drain();
    endtask

    task automatic test_random_traffic(int n, int unsigned src_pct, int unsigned snk_pct,
                                       logic [SIZE_W-1:0] size);
        set_bins(size, pick_base(size));
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        repeat (n) issue_random_item();
        drain();
    endtask

    // long receiver hold-off so the block backs up, then a full sender pause
    task automatic test_output_backpressure();
        set_bins(16'd3, 32'd100);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        holdoff_left  = 400;
        repeat (20) issue_random_item();
        drain();
        repeat (20) issue_random_item();
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_bins();
        test_register_extremes();
        test_random_traffic(350, 0, 0, 16'd1);
        test_random_traffic(350, 49, 0, 16'hFFFF);
        test_random_traffic(350, 0, 49, SIZE_W'($urandom_range(64, 2)));
        test_random_traffic(350, 15, 15, SIZE_W'($urandom_range(65535, 1)));
        test_output_backpressure();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_levels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
